@@ rtl/disc_row_span_generator_assert.svh @@
// Assertion macros shared by the disc row span generator RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DISC_ROW_SPAN_GENERATOR_ASSERT_SVH
`define DISC_ROW_SPAN_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/drs_pkg.sv @@
// Shared types and constants of the disc row span generator.
// Holds the microcode format, the program ROM and the status struct; no dependencies.
package drs_pkg;

  localparam int RADIUS_W = 6;
  localparam int COL_W    = 7;
  localparam int RSQ_W    = 11;
  localparam int SUM_W    = 12;
  localparam int STEP_W   = 3;

  // Program step addresses.
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_START  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ROWSET = 3'd2;
  localparam logic [STEP_W-1:0] STEP_GROW   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SHRINK = 3'd4;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_NEXT   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DONE   = 3'd7;

  // Jump conditions tested by the sequencer.
  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_INPUT  = 3'd2,
    COND_SKIP      = 3'd3,
    COND_GROW      = 3'd4,
    COND_SHRINK    = 3'd5,
    COND_OUT_BUSY  = 3'd6,
    COND_NOT_LAST  = 3'd7
  } cond_t;

  // Datapath actions.
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_LOAD     = 3'd1,
    ACT_INIT     = 3'd2,
    ACT_DYSQ     = 3'd3,
    ACT_INC_H    = 3'd4,
    ACT_DEC_H    = 3'd5,
    ACT_LOAD_OUT = 3'd6,
    ACT_NEXT_ROW = 3'd7
  } act_t;

  // One control word of the program.
  typedef struct packed {
    logic              in_ready;
    cond_t             cond;
    act_t              act;
    logic              act_on_jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Command from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    act_t act;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic skip;
    logic grow_ok;
    logic shrink_ok;
    logic out_busy;
    logic last;
  } flags_t;

  // The program: one control word per step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uw;
    unique case (step)
      STEP_IDLE:   uw = '{1'b1, COND_NO_INPUT, ACT_LOAD,     1'b0, STEP_IDLE};
      STEP_START:  uw = '{1'b0, COND_SKIP,     ACT_INIT,     1'b0, STEP_IDLE};
      STEP_ROWSET: uw = '{1'b0, COND_NEVER,    ACT_DYSQ,     1'b0, STEP_IDLE};
      STEP_GROW:   uw = '{1'b0, COND_GROW,     ACT_INC_H,    1'b1, STEP_GROW};
      STEP_SHRINK: uw = '{1'b0, COND_SHRINK,   ACT_DEC_H,    1'b1, STEP_SHRINK};
      STEP_EMIT:   uw = '{1'b0, COND_OUT_BUSY, ACT_LOAD_OUT, 1'b0, STEP_EMIT};
      STEP_NEXT:   uw = '{1'b0, COND_NOT_LAST, ACT_NEXT_ROW, 1'b1, STEP_ROWSET};
      STEP_DONE:   uw = '{1'b0, COND_ALWAYS,   ACT_NONE,     1'b0, STEP_IDLE};
      default:     uw = '{1'b0, COND_ALWAYS,   ACT_NONE,     1'b0, STEP_IDLE};
    endcase
    return uw;
  endfunction

endpackage

@@ rtl/drs_in_if.sv @@
// Input channel of the disc row span generator: one radius per word.
// Depends on nothing.
interface drs_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] radius;

  modport source (output valid, output radius, input ready);
  modport sink (input valid, input radius, output ready);
endinterface

@@ rtl/drs_out_if.sv @@
// Output channel of the disc row span generator: one row run per word.
// Depends on nothing.
interface drs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] row;
  logic [6:0] start_col;
  logic [6:0] end_col;
  logic       last_run;

  modport source (output valid, output row, output start_col, output end_col,
                  output last_run, input ready);
  modport sink (input valid, input row, input start_col, input end_col,
                input last_run, output ready);
endinterface

@@ rtl/disc_row_span_generator.sv @@
// Top level of the disc row span generator: sequencer plus datapath.
// Depends on drs_pkg, drs_in_if, drs_out_if, drs_sequencer, drs_datapath and the
// assertion header.
//
//   channel  direction  word
//   req      in         radius (6 bits)
//   span     out        row, start_col, end_col (7 bits each), last_run
//
// A new radius R gives 2R-1 words, one per row from 1 to 2R-1. Each row passes
// through the rowset, grow, shrink, emit and next steps; the grow and shrink steps
// repeat once per change of its half width. A radius runs from the idle and start
// steps through its rows to the done step. A repeated or zero radius gives no word:
// the start step jumps back to idle.
// rst clears the step counter, the stored radius and the output valid flag.
// A word waits in the output register while the next row is searched; a stalled
// sink holds the sequencer in its emit step.
module disc_row_span_generator #(
  parameter int MAX_RADIUS = 32
) (
  input logic       clk,
  input logic       rst,
  drs_in_if.sink    req,
  drs_out_if.source span
);
  import drs_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  drs_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .flags    (flags),
    .cmd      (cmd)
  );

  drs_datapath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .radius (req.radius),
    .flags  (flags),
    .span   (span)
  );

  assign req.ready = cmd.in_ready;

`include "disc_row_span_generator_assert.svh"

  // A new word is loaded only when the pending one leaves in the same cycle.
  `DRS_ASSERT_NOW(a_no_overwrite, (cmd.act == ACT_LOAD_OUT) && span.valid, span.ready, "output word overwritten")
  // Every run is at least one cell wide.
  `DRS_ASSERT_NOW(a_run_width, span.valid, span.end_col > span.start_col, "empty run emitted")
  // After taking a radius the sequencer leaves its idle step.
  `DRS_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "second radius taken at once")

endmodule

@@ rtl/drs_sequencer.sv @@
// Microcode sequencer: step counter, program ROM and jump logic.
// Depends on drs_pkg.
module drs_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  drs_pkg::flags_t flags,
  output drs_pkg::cmd_t   cmd
);
  import drs_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ucode_t            uw;
  logic              take;
  logic              act_fire;

  assign uw = ucode_rom(pc);

  // Evaluate the jump condition of the current step.
  always_comb begin
    unique case (uw.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = !in_valid;
      COND_SKIP:     take = flags.skip;
      COND_GROW:     take = flags.grow_ok;
      COND_SHRINK:   take = flags.shrink_ok;
      COND_OUT_BUSY: take = flags.out_busy;
      COND_NOT_LAST: take = !flags.last;
      default:       take = 1'b0;
    endcase
  end

  // The action fires either with the jump or with the fall-through.
  assign act_fire     = uw.act_on_jump ? take : !take;
  assign cmd.act      = act_fire ? uw.act : ACT_NONE;
  assign cmd.in_ready = uw.in_ready;
  assign pc_next      = take ? uw.target : pc + STEP_W'(1);

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/drs_datapath.sv @@
// Datapath: radius registers, row scan, half-width search and output register.
// Depends on drs_pkg and drs_out_if.
module drs_datapath #(
  parameter int MAX_RADIUS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  drs_pkg::cmd_t   cmd,
  input  logic [5:0]      radius,
  output drs_pkg::flags_t flags,
  drs_out_if.source       span
);
  import drs_pkg::*;

  localparam logic [RADIUS_W-1:0] RadiusMax = RADIUS_W'(MAX_RADIUS);

  logic [RADIUS_W-1:0] stored;
  logic                skip;
  logic [RADIUS_W-1:0] r;
  logic [RSQ_W-1:0]    rr;
  logic [COL_W-1:0]    row;
  logic [RSQ_W-1:0]    dysq;
  logic [RADIUS_W-1:0] h;
  logic                out_valid;
  logic [COL_W-1:0]    out_row;
  logic [COL_W-1:0]    out_start;
  logic [COL_W-1:0]    out_end;
  logic                out_last;

  logic [RADIUS_W-1:0] rc;
  logic [COL_W-1:0]    r_ext;
  logic [COL_W-1:0]    top;
  logic [RADIUS_W-1:0] dy;
  logic [RSQ_W-1:0]    h_ext;
  logic [RSQ_W-1:0]    hsq;
  logic [RSQ_W-1:0]    h1sq;
  logic [SUM_W-1:0]    sum_h;
  logic [SUM_W-1:0]    sum_h1;
  logic                last_row;

  // Clamp the incoming radius.
  assign rc = (radius > RadiusMax) ? RadiusMax : radius;

  // Row geometry: last row is 2R-1, dy is the distance to the center row.
  assign r_ext    = COL_W'(r);
  assign top      = {r, 1'b0} - COL_W'(1);
  assign last_row = (row == top);
  assign dy       = (row >= r_ext) ? RADIUS_W'(row - r_ext) : RADIUS_W'(r_ext - row);

  // Squared-distance compares for the current and the next half width.
  assign h_ext  = RSQ_W'(h);
  assign hsq    = h_ext * h_ext;
  assign h1sq   = (h_ext + RSQ_W'(1)) * (h_ext + RSQ_W'(1));
  assign sum_h  = SUM_W'(hsq) + SUM_W'(dysq);
  assign sum_h1 = SUM_W'(h1sq) + SUM_W'(dysq);

  assign flags.skip      = skip;
  assign flags.grow_ok   = sum_h1 < SUM_W'(rr);
  assign flags.shrink_ok = sum_h >= SUM_W'(rr);
  assign flags.out_busy  = out_valid && !span.ready;
  assign flags.last      = last_row;

  // Control state: stored radius and output word valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.act == ACT_LOAD) begin
        stored <= rc;
      end
      if (cmd.act == ACT_LOAD_OUT) begin
        out_valid <= 1'b1;
      end else if (span.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers driven by the current action.
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_LOAD: begin
        r    <= rc;
        rr   <= RSQ_W'(rc) * RSQ_W'(rc);
        skip <= (rc == stored) || (rc == '0);
      end
      ACT_INIT: begin
        row <= COL_W'(1);
        h   <= '0;
      end
      ACT_DYSQ: begin
        dysq <= RSQ_W'(dy) * RSQ_W'(dy);
      end
      ACT_INC_H: begin
        h <= h + RADIUS_W'(1);
      end
      ACT_DEC_H: begin
        h <= h - RADIUS_W'(1);
      end
      ACT_LOAD_OUT: begin
        out_row   <= row;
        out_start <= r_ext - COL_W'(h);
        out_end   <= r_ext + COL_W'(h) + COL_W'(1);
        out_last  <= last_row;
      end
      ACT_NEXT_ROW: begin
        row <= row + COL_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign span.valid     = out_valid;
  assign span.row       = out_row;
  assign span.start_col = out_start;
  assign span.end_col   = out_end;
  assign span.last_run  = out_last;

endmodule

@@ tb/tb_disc_row_span_generator.sv @@
// Self-checking testbench for disc_row_span_generator: radius words in, row run words out.
// Depends on drs_pkg, drs_in_if, drs_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_disc_row_span_generator;
  import drs_pkg::*;

  localparam int MaxRadius = 32;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 40;
  localparam int DirectedCount = 20;
  localparam int RandomCount = 220;
  localparam int TailCount = 30;

  // One expected run word on the span channel.
  typedef struct packed {
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] start_col;
    logic [COL_W-1:0] end_col;
    logic             last_run;
  } run_word_t;

  logic clk;
  logic rst;

  drs_in_if  req ();
  drs_out_if span ();

  disc_row_span_generator #(
    .MAX_RADIUS(MaxRadius)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .span(span.source)
  );

  // Predictor state and the runs still owed by the block.
  logic [RADIUS_W-1:0] held_radius;
  run_word_t           pending_runs[$];
  int                  mismatch_count;
  int                  quiet_cycles;
  int                  ready_hold;
  bit                  idle_on;
  run_word_t           got_run;
  run_word_t           want_run;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Work out the runs of one radius word and queue them. A word that matches
  // the held radius queues nothing.
  function automatic void predict_runs(input logic [RADIUS_W-1:0] raw);
    int        rad;
    int        dy;
    int        lim;
    int        half;
    run_word_t w;
    rad = (raw > MaxRadius) ? MaxRadius : int'(raw);
    if (rad == int'(held_radius)) begin
      return;
    end
    held_radius = RADIUS_W'(rad);
    for (int r = 1; r <= 2 * rad - 1; r++) begin
      dy = (r >= rad) ? r - rad : rad - r;
      lim = rad * rad - dy * dy;
      half = rad - 1;
      while (half > 0 && half * half >= lim) begin
        half--;
      end
      w.row = COL_W'(r);
      w.start_col = COL_W'(rad - half);
      w.end_col = COL_W'(rad + half + 1);
      w.last_run = (r == 2 * rad - 1);
      pending_runs = {pending_runs, w};
    end
  endfunction

  // Offer one radius word, with an optional gap before it, and wait until
  // it is taken. Valid stays high on return so back-to-back words need no
  // second assignment in the same step.
  task automatic send_radius(input logic [RADIUS_W-1:0] r);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.radius <= r;
    do @(posedge clk); while (!(req.valid && req.ready));
    predict_runs(r);
  endtask

  // Sink side: random stall bursts while idling is on, otherwise always ready.
  always @(posedge clk) begin
    if (rst) begin
      ready_hold = 0;
      span.ready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold--;
      span.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 18) - 1;
      span.ready <= 1'b0;
    end else begin
      span.ready <= 1'b1;
    end
  end

  // Compare each accepted run word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && span.valid && span.ready) begin
      got_run = '{span.row, span.start_col, span.end_col, span.last_run};
      if (pending_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected run word row=%0d start=%0d end=%0d last=%0b",
                                  got_run.row, got_run.start_col, got_run.end_col,
                                  got_run.last_run));
      end else begin
        want_run = pending_runs.pop_front();
        if (got_run.row !== want_run.row)
          report_mismatch($sformatf("row got %0d want %0d", got_run.row, want_run.row));
        if (got_run.start_col !== want_run.start_col)
          report_mismatch($sformatf("row %0d start_col got %0d want %0d", want_run.row,
                                    got_run.start_col, want_run.start_col));
        if (got_run.end_col !== want_run.end_col)
          report_mismatch($sformatf("row %0d end_col got %0d want %0d", want_run.row,
                                    got_run.end_col, want_run.end_col));
        if (got_run.last_run !== want_run.last_run)
          report_mismatch($sformatf("row %0d last_run got %0b want %0b", want_run.row,
                                    got_run.last_run, want_run.last_run));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (span.valid && span.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no word moved for %0d cycles", StallLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Zero and repeated radii right after reset, small discs, clamping and
  // each single radius bit.
  task automatic test_directed_radii();
    logic [RADIUS_W-1:0] list[DirectedCount] = '{
      6'd0, 6'd0, 6'd1, 6'd2, 6'd3, 6'd1, 6'd32, 6'd63, 6'd33, 6'd31,
      6'd0, 6'd0, 6'd5, 6'd21, 6'd42, 6'd16, 6'd8, 6'd4, 6'd32, 6'd1
    };
    idle_on = 1'b1;
    foreach (list[i]) send_radius(list[i]);
  endtask

  // Pick a radius: mostly fresh in-range discs, some repeats, clamped and zero values.
  function automatic logic [RADIUS_W-1:0] pick_radius();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return held_radius;
    if (pick < 20) return RADIUS_W'($urandom_range(MaxRadius + 1, 63));
    if (pick < 25) return '0;
    if (pick < 75) return RADIUS_W'($urandom_range(1, 12));
    return RADIUS_W'($urandom_range(1, MaxRadius));
  endfunction

  // Random radii; with allow_idle set, idling is switched on and off in stretches.
  task automatic test_random_radii(input int count, input bit allow_idle);
    int  done;
    done = 0;
    while (done < count) begin
      if (done % 20 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      send_radius(pick_radius());
      done++;
    end
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.radius = '0;
    span.ready = 1'b0;
    held_radius = '0;
    mismatch_count = 0;
    quiet_cycles = 0;
    ready_hold = 0;
    idle_on = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_radii();
    test_random_radii(RandomCount, 1'b1);
    test_random_radii(TailCount, 1'b0);

    // Drain: every owed run word must arrive, then nothing more may follow.
    req.valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/drs_pkg.sv
rtl/drs_in_if.sv
rtl/drs_out_if.sv
rtl/drs_sequencer.sv
rtl/drs_datapath.sv
rtl/disc_row_span_generator.sv
tb/tb_disc_row_span_generator.sv
